FILE: src/emsr_pkg.sv
// ----------------------------------------------------------------------------
// emsr_pkg
// Types and constants for the encoder motor speed regulator.
// ----------------------------------------------------------------------------
package emsr_pkg;

  localparam int unsigned DUTY_W   = 8;
  localparam int unsigned SPD_W    = 16;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned EDGE_W   = 32;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned DIR_W    = 2;
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned ACC_W    = 48;
  localparam int unsigned STEP_W   = 4;

  localparam logic [SPD_W-1:0]  SPD_MAX    = 16'hFFFF;
  localparam logic [CNT_W-1:0]  CNT_MAX    = 16'hFFFF;
  localparam logic [15:0]       MS_PER_S   = 16'd1000;
  localparam logic [15:0]       MIN_TARGET = 16'd150;
  localparam logic [DUTY_W-1:0] DUTY_MAX   = 8'hFF;
  localparam logic [STEP_W-1:0] STEP_LAST  = 4'hF;

  localparam logic [DIR_W-1:0] DIR_STOP = 2'b00;
  localparam logic [DIR_W-1:0] DIR_FWD  = 2'b01;
  localparam logic [DIR_W-1:0] DIR_BWD  = 2'b10;

  localparam logic [15:0] RST_WHEEL_MM = 16'd200;
  localparam logic [15:0] RST_PPR      = 16'd20;
  localparam logic [15:0] RST_GAIN     = 16'd256;
  localparam logic [7:0]  RST_FLOOR    = 8'd0;
  localparam logic [7:0]  RST_BOOST    = 8'd0;
  localparam logic [15:0] RST_BOOST_SP = 16'd0;
  localparam logic [15:0] RST_PERIOD   = 16'd300;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 2'd0,
    KIND_EDGE   = 2'd1,
    KIND_TARGET = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_WHEEL_MM   = 3'd0,
    REG_PPR        = 3'd1,
    REG_GAIN       = 3'd2,
    REG_FLOOR_DUTY = 3'd3,
    REG_BOOST_DUTY = 3'd4,
    REG_BOOST_SP   = 3'd5,
    REG_PERIOD     = 3'd6
  } reg_idx_e;

  typedef enum logic [3:0] {
    UPD_IDLE,
    UPD_MUL_EW,
    UPD_MUL_K,
    UPD_MUL_PD,
    UPD_DIV_CHK,
    UPD_DIV,
    UPD_CTRL,
    UPD_MUL_G,
    UPD_FIN
  } upd_state_e;

  typedef struct packed {
    logic [15:0]       wheel_mm;
    logic [15:0]       ppr;
    logic [15:0]       gain;
    logic [DUTY_W-1:0] floor_duty;
    logic [DUTY_W-1:0] boost_duty;
    logic [SPD_W-1:0]  boost_speed;
    logic [CNT_W-1:0]  period_ms;
  } cfg_t;

  typedef struct packed {
    logic [SPD_W-1:0]  speed;
    logic [DUTY_W-1:0] duty;
    logic [DIR_W-1:0]  dir;
  } upd_res_t;

endpackage

FILE: src/emsr_if.sv
// ----------------------------------------------------------------------------
// emsr_in_if / emsr_out_if
// Valid/ready channels for event items and status items.
// ----------------------------------------------------------------------------
interface emsr_in_if import emsr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [15:0]       target_speed;

  modport source (output valid, kind, target_speed, input ready);
  modport sink   (input valid, kind, target_speed, output ready);
endinterface

interface emsr_out_if import emsr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DUTY_W-1:0]   duty;
  logic                drive_forward;
  logic                drive_backward;
  logic [SPD_W-1:0]    measured_speed;
  logic [EDGE_W-1:0]   edge_total;
  logic                update_done;

  modport source (output valid, duty, drive_forward, drive_backward, measured_speed,
                  edge_total, update_done, input ready);
  modport sink   (input valid, duty, drive_forward, drive_backward, measured_speed,
                  edge_total, update_done, output ready);
endinterface

FILE: src/emsr_update.sv
// ----------------------------------------------------------------------------
// emsr_update
// Control update: speed measurement and proportional duty correction, built
// on one shift-add multiplier and a restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module emsr_update import emsr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [CNT_W-1:0]   edges_i,
  input  logic [CNT_W-1:0]   dt_i,
  input  cfg_t               cfg_i,
  input  logic signed [15:0] target_i,
  input  logic [DUTY_W-1:0]  duty_i,
  output logic               busy_o,
  output logic               done_o,
  output upd_res_t           res_o
);

  upd_state_e         state_q, state_d;
  logic [STEP_W-1:0]  cnt_q, cnt_d;
  logic [ACC_W-1:0]   mcand_q, mcand_d;
  logic [15:0]        mplier_q, mplier_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [ACC_W-1:0]   rem_q, rem_d;
  logic [ACC_W-1:0]   dvs_q, dvs_d;
  logic [SPD_W-1:0]   quo_q, quo_d;
  logic [SPD_W-1:0]   speed_q, speed_d;
  logic [CNT_W-1:0]   dt_q, dt_d;
  logic [DIR_W-1:0]   dir_q, dir_d;
  logic               neg_q, neg_d;
  logic               stop_q, stop_d;

  logic [ACC_W-1:0]   acc_step;
  logic               step_last;
  logic               rem_ge;
  logic [15:0]        ppr_eff;
  logic [16:0]        tgt_ext;
  logic [16:0]        tgt_mag;
  logic [17:0]        err;
  logic [16:0]        err_abs;
  logic [24:0]        delta;
  logic [26:0]        delta_s;
  logic [26:0]        dsum;
  logic [DUTY_W-1:0]  duty_fl;
  logic [DUTY_W-1:0]  duty_fin;

  assign acc_step  = mplier_q[0] ? acc_q + mcand_q : acc_q;
  assign step_last = (cnt_q == STEP_LAST);
  assign rem_ge    = (rem_q >= dvs_q);
  assign ppr_eff   = (cfg_i.ppr == 16'd0) ? 16'd1 : cfg_i.ppr;

  assign tgt_ext = {target_i[15], target_i};
  assign tgt_mag = tgt_ext[16] ? (~tgt_ext + 17'd1) : tgt_ext;
  assign err     = {1'b0, tgt_mag} - {2'b00, speed_q};
  assign err_abs = err[17] ? 17'(~err + 18'd1) : err[16:0];

  // trunc(gain*err/256) toward zero: shift the magnitude, then apply sign
  assign delta   = acc_q[32:8];
  assign delta_s = neg_q ? (~{2'b00, delta} + 27'd1) : {2'b00, delta};
  assign dsum    = {19'd0, duty_i} + delta_s;
  assign duty_fl = (speed_q < cfg_i.boost_speed) ? cfg_i.boost_duty : cfg_i.floor_duty;

  always_comb begin
    if ($signed(dsum) < $signed({19'd0, duty_fl})) begin
      duty_fin = duty_fl;
    end else if ($signed(dsum) > $signed({19'd0, DUTY_MAX})) begin
      duty_fin = DUTY_MAX;
    end else begin
      duty_fin = dsum[DUTY_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      UPD_IDLE:    if (start_i) state_d = UPD_MUL_EW;
      UPD_MUL_EW:  if (step_last) state_d = UPD_MUL_K;
      UPD_MUL_K:   if (step_last) state_d = UPD_MUL_PD;
      UPD_MUL_PD:  if (step_last) state_d = UPD_DIV_CHK;
      UPD_DIV_CHK: state_d = rem_ge ? UPD_CTRL : UPD_DIV;
      UPD_DIV:     if (step_last) state_d = UPD_CTRL;
      UPD_CTRL:    state_d = (target_i == 16'sd0) ? UPD_FIN : UPD_MUL_G;
      UPD_MUL_G:   if (step_last) state_d = UPD_FIN;
      UPD_FIN:     state_d = UPD_IDLE;
      default:     state_d = UPD_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    cnt_d    = cnt_q + STEP_W'(1);
    mcand_d  = {mcand_q[ACC_W-2:0], 1'b0};
    mplier_d = {1'b0, mplier_q[15:1]};
    acc_d    = acc_step;
    rem_d    = rem_q;
    dvs_d    = dvs_q;
    quo_d    = quo_q;
    speed_d  = speed_q;
    dt_d     = dt_q;
    dir_d    = dir_q;
    neg_d    = neg_q;
    stop_d   = stop_q;
    case (state_q)
      UPD_IDLE: begin
        cnt_d    = '0;
        mcand_d  = {32'd0, edges_i};
        mplier_d = cfg_i.wheel_mm;
        acc_d    = '0;
        dt_d     = dt_i;
        stop_d   = 1'b0;
      end
      UPD_MUL_EW: begin
        if (step_last) begin
          mcand_d  = acc_step;
          mplier_d = MS_PER_S;
          acc_d    = '0;
        end
      end
      UPD_MUL_K: begin
        if (step_last) begin
          rem_d    = acc_step;
          mcand_d  = {32'd0, ppr_eff};
          mplier_d = dt_q;
          acc_d    = '0;
        end
      end
      UPD_MUL_PD: begin
        if (step_last) begin
          dvs_d = {acc_step[31:0], 16'd0};
        end
      end
      UPD_DIV_CHK: begin
        cnt_d = '0;
        quo_d = '0;
        dvs_d = {1'b0, dvs_q[ACC_W-1:1]};
        if (rem_ge) begin
          speed_d = SPD_MAX;
        end
      end
      UPD_DIV: begin
        quo_d = {quo_q[SPD_W-2:0], rem_ge};
        dvs_d = {1'b0, dvs_q[ACC_W-1:1]};
        if (rem_ge) begin
          rem_d = rem_q - dvs_q;
        end
        if (step_last) begin
          speed_d = {quo_q[SPD_W-2:0], rem_ge};
        end
      end
      UPD_CTRL: begin
        cnt_d    = '0;
        mcand_d  = {31'd0, err_abs};
        mplier_d = cfg_i.gain;
        acc_d    = '0;
        neg_d    = err[17];
        if (target_i == 16'sd0) begin
          stop_d = 1'b1;
        end else begin
          dir_d = target_i[15] ? DIR_BWD : DIR_FWD;
        end
      end
      UPD_MUL_G: begin
      end
      UPD_FIN: begin
        acc_d = acc_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= UPD_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
    rem_q    <= rem_d;
    dvs_q    <= dvs_d;
    quo_q    <= quo_d;
    speed_q  <= speed_d;
    dt_q     <= dt_d;
    dir_q    <= dir_d;
    neg_q    <= neg_d;
    stop_q   <= stop_d;
  end

  assign busy_o = (state_q != UPD_IDLE);
  assign done_o = (state_q == UPD_FIN);

  always_comb begin
    if (stop_q) begin
      res_o.speed = '0;
      res_o.duty  = '0;
      res_o.dir   = DIR_STOP;
    end else begin
      res_o.speed = speed_q;
      res_o.duty  = duty_fin;
      res_o.dir   = dir_q;
    end
  end

endmodule

FILE: src/encoder_motor_speed_regulator_core.sv
// ----------------------------------------------------------------------------
// encoder_motor_speed_regulator_core
// Encoder-based motor speed regulator with proportional duty correction.
// ----------------------------------------------------------------------------
// Each input item is a millisecond tick, an encoder edge or a new target
// speed; each yields one status item (duty, drive lines, measured speed,
// edge total, update flag). Edges, targets and ticks that do not end a
// control period are held pending and reach the output register once it
// is free or being read. A tick that ends a period runs the control
// update on the shared 16-step shift-add multiplier (edges x wheel, x1000,
// pulses x dt, gain x error) and the 16-step bit-serial divider, then its
// status item is held pending in the same way. A finished item waiting at
// the output does not stop the next item from being taken.
// ----------------------------------------------------------------------------
module encoder_motor_speed_regulator_core import emsr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  emsr_in_if.sink            in_if,
  emsr_out_if.source         out_if,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t               cfg_q;
  logic [CNT_W-1:0]   elapsed_q, elapsed_d;
  logic [CNT_W-1:0]   edges_q, edges_d;
  logic [EDGE_W-1:0]  all_edges_q, all_edges_d;
  logic signed [15:0] target_q, target_d;
  logic [SPD_W-1:0]   speed_q, speed_d;
  logic [DUTY_W-1:0]  duty_q, duty_d;
  logic [DIR_W-1:0]   dir_q, dir_d;
  logic               pend_q, pend_d;
  logic               pend_done_q, pend_done_d;
  logic               out_valid_q, out_valid_d;
  logic               out_load;

  logic [DUTY_W-1:0]  out_duty_q;
  logic [DIR_W-1:0]   out_dir_q;
  logic [SPD_W-1:0]   out_speed_q;
  logic [EDGE_W-1:0]  out_edges_q;
  logic               out_done_q;

  logic               accept;
  logic [CNT_W-1:0]   elapsed_inc;
  logic               period_end;
  logic signed [15:0] target_adj;
  logic               upd_start;
  logic               upd_busy;
  logic               upd_done;
  upd_res_t           upd_res;
  logic               apb_wr;
  reg_idx_e           apb_idx;

  // configuration port
  assign pready  = 1'b1;
  assign apb_wr  = psel && penable && pwrite;
  assign apb_idx = reg_idx_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wheel_mm    <= RST_WHEEL_MM;
      cfg_q.ppr         <= RST_PPR;
      cfg_q.gain        <= RST_GAIN;
      cfg_q.floor_duty  <= RST_FLOOR;
      cfg_q.boost_duty  <= RST_BOOST;
      cfg_q.boost_speed <= RST_BOOST_SP;
      cfg_q.period_ms   <= RST_PERIOD;
    end else if (apb_wr) begin
      case (apb_idx)
        REG_WHEEL_MM:   cfg_q.wheel_mm    <= pwdata[15:0];
        REG_PPR:        cfg_q.ppr         <= pwdata[15:0];
        REG_GAIN:       cfg_q.gain        <= pwdata[15:0];
        REG_FLOOR_DUTY: cfg_q.floor_duty  <= pwdata[DUTY_W-1:0];
        REG_BOOST_DUTY: cfg_q.boost_duty  <= pwdata[DUTY_W-1:0];
        REG_BOOST_SP:   cfg_q.boost_speed <= pwdata[15:0];
        REG_PERIOD:     cfg_q.period_ms   <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (apb_idx)
      REG_WHEEL_MM:   prdata = {16'd0, cfg_q.wheel_mm};
      REG_PPR:        prdata = {16'd0, cfg_q.ppr};
      REG_GAIN:       prdata = {16'd0, cfg_q.gain};
      REG_FLOOR_DUTY: prdata = {24'd0, cfg_q.floor_duty};
      REG_BOOST_DUTY: prdata = {24'd0, cfg_q.boost_duty};
      REG_BOOST_SP:   prdata = {16'd0, cfg_q.boost_speed};
      REG_PERIOD:     prdata = {16'd0, cfg_q.period_ms};
      default:        prdata = '0;
    endcase
  end

  // event handling
  assign in_if.ready = !upd_busy && !pend_q;
  assign accept      = in_if.valid && in_if.ready;
  assign elapsed_inc = (elapsed_q == CNT_MAX) ? elapsed_q : elapsed_q + CNT_W'(1);
  assign period_end  = (elapsed_inc >= cfg_q.period_ms);

  always_comb begin
    target_adj = in_if.target_speed;
    if (!in_if.target_speed[15] && (in_if.target_speed != 16'sd0) &&
        (in_if.target_speed < $signed(MIN_TARGET))) begin
      target_adj = $signed(MIN_TARGET);
    end else if (in_if.target_speed[15] &&
                 (in_if.target_speed > -$signed(MIN_TARGET))) begin
      target_adj = -$signed(MIN_TARGET);
    end
  end

  assign out_load = pend_q && (!out_valid_q || out_if.ready);

  always_comb begin
    elapsed_d   = elapsed_q;
    edges_d     = edges_q;
    all_edges_d = all_edges_q;
    target_d    = target_q;
    speed_d     = speed_q;
    duty_d      = duty_q;
    dir_d       = dir_q;
    pend_d      = pend_q;
    pend_done_d = pend_done_q;
    upd_start   = 1'b0;
    if (accept) begin
      pend_d      = 1'b1;
      pend_done_d = 1'b0;
      case (kind_e'(in_if.kind))
        KIND_TICK: begin
          if (period_end) begin
            elapsed_d = '0;
            edges_d   = '0;
            upd_start = 1'b1;
            pend_d    = 1'b0;
          end else begin
            elapsed_d = elapsed_inc;
          end
        end
        KIND_EDGE: begin
          if (edges_q != CNT_MAX) begin
            edges_d = edges_q + CNT_W'(1);
          end
          all_edges_d = all_edges_q + EDGE_W'(1);
        end
        KIND_TARGET: begin
          target_d = target_adj;
          if (target_adj == 16'sd0) begin
            duty_d  = '0;
            speed_d = '0;
            dir_d   = DIR_STOP;
          end
        end
        default: begin
        end
      endcase
    end
    if (upd_done) begin
      speed_d     = upd_res.speed;
      duty_d      = upd_res.duty;
      dir_d       = upd_res.dir;
      pend_d      = 1'b1;
      pend_done_d = 1'b1;
    end
    if (out_load) begin
      pend_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q   <= '0;
      edges_q     <= '0;
      all_edges_q <= '0;
      target_q    <= '0;
      speed_q     <= '0;
      duty_q      <= '0;
      dir_q       <= DIR_STOP;
      pend_q      <= 1'b0;
      pend_done_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      elapsed_q   <= elapsed_d;
      edges_q     <= edges_d;
      all_edges_q <= all_edges_d;
      target_q    <= target_d;
      speed_q     <= speed_d;
      duty_q      <= duty_d;
      dir_q       <= dir_d;
      pend_q      <= pend_d;
      pend_done_q <= pend_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_duty_q  <= duty_q;
      out_dir_q   <= dir_q;
      out_speed_q <= speed_q;
      out_edges_q <= all_edges_q;
      out_done_q  <= pend_done_q;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.duty           = out_duty_q;
  assign out_if.drive_forward  = out_dir_q[0];
  assign out_if.drive_backward = out_dir_q[1];
  assign out_if.measured_speed = out_speed_q;
  assign out_if.edge_total     = out_edges_q;
  assign out_if.update_done    = out_done_q;

  emsr_update u_update (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (upd_start),
    .edges_i  (edges_q),
    .dt_i     (elapsed_inc),
    .cfg_i    (cfg_q),
    .target_i (target_q),
    .duty_i   (duty_q),
    .busy_o   (upd_busy),
    .done_o   (upd_done),
    .res_o    (upd_res)
  );

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_start |-> !upd_busy)
    else $error("update started while busy");

  a_duty_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (duty_q != '0) |-> (dir_q != DIR_STOP))
    else $error("nonzero duty with drive lines off");

  a_dir_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(dir_q[0] && dir_q[1]))
    else $error("both drive lines high");

  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_done |-> !pend_q)
    else $error("update finished over a pending item");

  a_pend_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(pend_q) |-> out_valid_q)
    else $error("pending item lost");
`endif

endmodule
